@@ rtl/assert_macros.svh @@
// Assertion helpers used by vertex_transform_persp_divide_core.
// All checks sample on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VTPD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/vtpd_pkg.sv @@
// ----------------------------------------------------------------------------
// vtpd_pkg
// Widths, register map and reset values of the vertex transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpd_pkg;

    localparam int NumRegs  = 8;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 64;
    localparam int CoordW   = 32;
    localparam int ProdW    = 2 * CoordW;
    localparam int SumW     = 50;   // floored dot product, |value| < 2^48
    localparam int MagW     = 48;   // magnitude of a dot product
    localparam int DivSteps = 33;   // quotient bits produced by the divider
    localparam int FracW    = 16;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [SumW-1:0]   dot_t;

    localparam logic [CfgDataW-1:0] CfgReset [NumRegs] = '{
        64'h0000_0001_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0001_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    localparam logic [CoordW-1:0] CoordMax = 32'h7FFF_FFFF;
    localparam logic [CoordW-1:0] CoordMin = 32'h8000_0000;

endpackage

`default_nettype wire

@@ rtl/vertex_transform_persp_divide_core.sv @@
// ----------------------------------------------------------------------------
// vertex_transform_persp_divide_core
// 4x4 homogeneous transform of a Q16.16 point with perspective divide.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries pos_x, pos_y, pos_z (Q16.16).
//   Output channel out_valid/out_ready carries res_x, res_y, res_z and the
//   w_was_zero and saturated flags, one result per request, in order.
//   Config channel cfg_valid/cfg_ready (always ready) writes matrix register
//   cfg_index with cfg_data; indexes above 7 are dropped. Write only when
//   no request is in flight.
//   Pipeline: a request passes through 12 multipliers, an adder stage, a
//   sign/magnitude stage, a 33-stage restoring divider (one quotient bit per
//   stage, three lanes), and the output register.
//   Throughput: one request per cycle while out_ready is high.
//   Stall: when the output register holds a result and out_ready is low,
//   the whole pipeline freezes and in_ready drops; nothing is lost.
//   Reset: all valid bits clear, matrix registers load CfgReset from vtpd_pkg.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vertex_transform_persp_divide_core
    import vtpd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CfgIdxW-1:0]    cfg_index,
    input  wire logic [CfgDataW-1:0]   cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [CoordW-1:0] pos_x,
    input  wire logic signed [CoordW-1:0] pos_y,
    input  wire logic signed [CoordW-1:0] pos_z,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [CoordW-1:0]   res_x,
    output logic signed [CoordW-1:0]   res_y,
    output logic signed [CoordW-1:0]   res_z,
    output logic                       w_was_zero,
    output logic                       saturated
);

    logic [CfgDataW-1:0] mat_reg [NumRegs];
    coord_t              elem [4][4];
    coord_t              pin [3];
    logic                adv;

    // stage 1: products, [column][row]
    logic                     v1_reg;
    logic signed [ProdW-1:0]  prod_reg [4][3];
    logic signed [ProdW-1:0]  prod_next [4][3];

    // stage 2: floored dot products
    logic                     v2_reg;
    dot_t                     dot_reg [4];
    dot_t                     dot_next [4];

    // divider pipe, index 0 is the sign/magnitude stage
    logic                     dv_reg    [DivSteps+1];
    logic [MagW-1:0]          den_reg   [DivSteps+1];
    logic                     wz_reg    [DivSteps+1];
    logic [MagW-1:0]          rem_reg   [DivSteps+1][3];
    logic [DivSteps-1:0]      nlo_reg   [DivSteps+1][3];
    logic [DivSteps-1:0]      quo_reg   [DivSteps+1][3];
    logic                     neg_reg   [DivSteps+1][3];
    logic                     ovf_reg   [DivSteps+1][3];
    coord_t                   zv_reg    [DivSteps+1][3];
    logic                     zsat_reg  [DivSteps+1][3];

    logic [MagW-1:0]          den_next;
    logic                     wz_next;
    logic [MagW-1:0]          rem0_next [3];
    logic [DivSteps-1:0]      nlo0_next [3];
    logic [DivSteps-1:0]      quo0_next [3];
    // entry s feeds divider stage s+1
    logic [MagW-1:0]          rem_next  [DivSteps][3];
    logic [DivSteps-1:0]      nlo_next  [DivSteps][3];
    logic [DivSteps-1:0]      quo_next  [DivSteps][3];
    logic                     neg_next  [3];
    logic                     ovf_next  [3];
    coord_t                   zv_next   [3];
    logic                     zsat_next [3];

    // output register
    logic                     out_valid_reg;
    coord_t                   res_reg [3];
    coord_t                   res_next [3];
    logic                     wz_out_reg;
    logic                     sat_out_reg;
    logic                     sat_out_next;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    assign pin[0] = pos_x;
    assign pin[1] = pos_y;
    assign pin[2] = pos_z;

    // even column in the high half, odd column in the low half
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if ((c & 1) != 0)
                    elem[r][c] = mat_reg[2*r + (c >> 1)][CoordW-1:0];
                else
                    elem[r][c] = mat_reg[2*r + (c >> 1)][CfgDataW-1:CoordW];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_next[c][r] = pin[r] * elem[r][c];
            end
        end
    end

    // exact sum, then floor to Q16.16 and add the translation term
    always_comb
    begin
        logic signed [ProdW+1:0] sum;
        for (int c = 0; c < 4; c++)
        begin
            sum = (ProdW+2)'(prod_reg[c][0]) + (ProdW+2)'(prod_reg[c][1])
                + (ProdW+2)'(prod_reg[c][2]);
            dot_next[c] = $signed(sum[ProdW+1:FracW]) + SumW'(elem[3][c]);
        end
    end

    // sign/magnitude, overflow precheck, undivided clamp
    always_comb
    begin
        dot_t            nabs;
        logic [MagW-1:0] mn;
        dot_t            dabs;
        dabs     = dot_reg[3][SumW-1] ? -dot_reg[3] : dot_reg[3];
        den_next = dabs[MagW-1:0];
        wz_next  = (dot_reg[3] == '0);
        for (int i = 0; i < 3; i++)
        begin
            nabs = dot_reg[i][SumW-1] ? -dot_reg[i] : dot_reg[i];
            mn   = nabs[MagW-1:0];
            neg_next[i] = dot_reg[i][SumW-1] != dot_reg[3][SumW-1];
            // quotient needs more than DivSteps bits when (mn >> 17) >= den
            ovf_next[i] = MagW'(mn[MagW-1:DivSteps-FracW]) >= den_next;
            rem0_next[i] = MagW'(mn[MagW-1:DivSteps-FracW]);
            nlo0_next[i] = {mn[DivSteps-FracW-1:0], {FracW{1'b0}}};
            quo0_next[i] = '0;
            if (dot_reg[i] > SumW'($signed(CoordMax)))
            begin
                zv_next[i]   = CoordMax;
                zsat_next[i] = 1'b1;
            end
            else if (dot_reg[i] < SumW'($signed(CoordMin)))
            begin
                zv_next[i]   = CoordMin;
                zsat_next[i] = 1'b1;
            end
            else
            begin
                zv_next[i]   = dot_reg[i][CoordW-1:0];
                zsat_next[i] = 1'b0;
            end
        end
    end

    // one restoring step per stage
    always_comb
    begin
        logic [MagW:0] trial;
        logic [MagW:0] diff;
        for (int s = 0; s < DivSteps; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial = {rem_reg[s][i], nlo_reg[s][i][DivSteps-1]};
                diff  = trial - {1'b0, den_reg[s]};
                nlo_next[s][i] = {nlo_reg[s][i][DivSteps-2:0], 1'b0};
                if (trial >= {1'b0, den_reg[s]})
                begin
                    rem_next[s][i] = diff[MagW-1:0];
                    quo_next[s][i] = {quo_reg[s][i][DivSteps-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][i] = trial[MagW-1:0];
                    quo_next[s][i] = {quo_reg[s][i][DivSteps-2:0], 1'b0};
                end
            end
        end
    end

    // final clamp and sign, or the undivided clamp when w was zero
    always_comb
    begin
        logic [DivSteps-1:0] q;
        logic [DivSteps-1:0] qn;
        sat_out_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            q  = quo_reg[DivSteps][i];
            qn = -q;
            if (wz_reg[DivSteps])
            begin
                res_next[i]  = zv_reg[DivSteps][i];
                sat_out_next = sat_out_next | zsat_reg[DivSteps][i];
            end
            else if (!neg_reg[DivSteps][i])
            begin
                if (ovf_reg[DivSteps][i] || q > DivSteps'(CoordMax))
                begin
                    res_next[i]  = CoordMax;
                    sat_out_next = 1'b1;
                end
                else
                begin
                    res_next[i] = q[CoordW-1:0];
                end
            end
            else
            begin
                if (ovf_reg[DivSteps][i] || q > DivSteps'(CoordMin))
                begin
                    res_next[i]  = CoordMin;
                    sat_out_next = 1'b1;
                end
                else
                begin
                    res_next[i] = qn[CoordW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NumRegs; k++)
                mat_reg[k] <= CfgReset[k];
        end
        else if (cfg_valid && cfg_index < CfgIdxW'(NumRegs))
        begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s <= DivSteps; s++)
                dv_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            for (int s = 0; s < DivSteps; s++)
                dv_reg[s+1] <= dv_reg[s];
            out_valid_reg <= dv_reg[DivSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg   <= prod_next;
            dot_reg    <= dot_next;
            den_reg[0] <= den_next;
            wz_reg[0]  <= wz_next;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i]  <= rem0_next[i];
                nlo_reg[0][i]  <= nlo0_next[i];
                quo_reg[0][i]  <= quo0_next[i];
                neg_reg[0][i]  <= neg_next[i];
                ovf_reg[0][i]  <= ovf_next[i];
                zv_reg[0][i]   <= zv_next[i];
                zsat_reg[0][i] <= zsat_next[i];
            end
            for (int s = 0; s < DivSteps; s++)
            begin
                den_reg[s+1] <= den_reg[s];
                wz_reg[s+1]  <= wz_reg[s];
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[s+1][i]  <= rem_next[s][i];
                    nlo_reg[s+1][i]  <= nlo_next[s][i];
                    quo_reg[s+1][i]  <= quo_next[s][i];
                    neg_reg[s+1][i]  <= neg_reg[s][i];
                    ovf_reg[s+1][i]  <= ovf_reg[s][i];
                    zv_reg[s+1][i]   <= zv_reg[s][i];
                    zsat_reg[s+1][i] <= zsat_reg[s][i];
                end
            end
            res_reg     <= res_next;
            wz_out_reg  <= wz_reg[DivSteps];
            sat_out_reg <= sat_out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign res_x      = res_reg[0];
    assign res_y      = res_reg[1];
    assign res_z      = res_reg[2];
    assign w_was_zero = wz_out_reg;
    assign saturated  = sat_out_reg;

    `VTPD_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v1_reg,
        "accepted request did not enter the multiplier stage")
    `VTPD_ASSERT_NEXT(a_stall_freezes, !adv && v2_reg, v2_reg && $stable(dot_reg[3]),
        "pipeline moved during a stall")
    `VTPD_ASSERT_IMPL(a_sat_means_clamped, out_valid && saturated,
        res_x == CoordMax || res_x == CoordMin || res_y == CoordMax ||
        res_y == CoordMin || res_z == CoordMax || res_z == CoordMin,
        "saturated set with no clamped coordinate")

endmodule

`default_nettype wire
